/* hw/rtl/b64lw_pkg.sv */
// shared types, character constants and alphabet lookup for the base64 line-wrap encoder
package b64lw_pkg;

    localparam int MAX_CHARS = 6;
    localparam int CNT_W     = 3;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_PAD = 8'd61;

    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    typedef struct packed {
        logic [15:0] pending;
        logic [1:0]  phase;
        logic [6:0]  line_chars;
    } b64lw_state_t;

    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          count;
    } b64lw_result_t;

    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
        begin
            c = 8'd65 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            c = 8'd71 + {2'b00, v};
        end
        else if (v < 6'd62)
        begin
            c = {2'b00, v} - 8'd4;
        end
        else if (v == 6'd62)
        begin
            c = 8'd43;
        end
        else
        begin
            c = 8'd47;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/base64_encoder_line_wrap_core.sv */
// Base64 encoder with CR LF line wrapping: top level with input register and char buffer
// A byte is taken into the input register in any cycle the register is free or moving on.
// From there one pass of logic encodes it against the group state; a byte that only waits
// for its group moves on without waiting for the buffer, while one that closes a group or
// a message loads four or six characters into the output buffer once it is empty or sends
// its last one. The output port sends one character per cycle while m_tready is high,
// and that single character port sets the rate. Padded tail characters do not count toward
// the line length, and the state returns to its reset values after each final byte.
module base64_encoder_line_wrap_core #(
    parameter int LINE_CHARS = 76
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte[7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char[7:0]
    output logic       m_tlast
);
    import b64lw_pkg::*;

    logic                      in_valid_reg;
    logic [7:0]                in_byte_reg;
    logic                      in_last_reg;
    b64lw_state_t              state_reg;
    b64lw_state_t              state_next;
    b64lw_result_t             enc_result;
    logic [MAX_CHARS-1:0][7:0] buf_reg;
    logic [MAX_CHARS-1:0][7:0] buf_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic                      pop;
    logic                      buf_free;
    logic                      advance;
    logic                      load;

    b64lw_group_enc #(
        .LINE_CHARS (LINE_CHARS)
    ) u_enc (
        .state_cur (state_reg),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .state_nxt (state_next),
        .result    (enc_result)
    );

    assign pop      = m_tvalid && m_tready;
    assign buf_free = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);
    assign advance  = in_valid_reg && ((enc_result.count == '0) || buf_free);
    assign load     = advance && (enc_result.count != '0);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = (cnt_reg == CNT_W'(1));

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            buf_next = enc_result.chars;
            cnt_next = enc_result.count;
        end
        else if (pop)
        begin
            buf_next = {8'h00, buf_reg[MAX_CHARS-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        buf_reg <= buf_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_CHARS))
        else $error("char buffer count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != 2'd3)
        else $error("group phase reached an unused code");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |-> enc_result.count != '0)
        else $error("final byte produced no characters");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> state_reg == '0)
        else $error("state not cleared after final byte");

endmodule

/* hw/rtl/b64lw_group_enc.sv */
// combinational encoder: one byte against current state gives next state and up to six chars
module b64lw_group_enc #(
    parameter int LINE_CHARS = 76
) (
    input  b64lw_pkg::b64lw_state_t  state_cur,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    output b64lw_pkg::b64lw_state_t  state_nxt,
    output b64lw_pkg::b64lw_result_t result
);
    import b64lw_pkg::*;

    localparam logic [6:0] LINE_LIM = 7'(LINE_CHARS);

    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  t0;
    logic [7:0]  t1;
    logic [6:0]  line_sum;
    b64lw_state_t st;

    assign b0       = state_cur.pending[15:8];
    assign b1       = state_cur.pending[7:0];
    assign line_sum = state_cur.line_chars + 7'd4;

    always_comb
    begin
        st           = state_cur;
        result.chars = '0;
        result.count = '0;
        case (state_cur.phase)
            PHASE_TWO:
            begin
                result.chars[0] = b64_sym(b0[7:2]);
                result.chars[1] = b64_sym({b0[1:0], b1[7:4]});
                result.chars[2] = b64_sym({b1[3:0], data_byte[7:6]});
                result.chars[3] = b64_sym(data_byte[5:0]);
                result.count    = CNT_W'(4);
                st.line_chars   = line_sum;
                if (line_sum >= LINE_LIM)
                begin
                    result.chars[4] = CHAR_CR;
                    result.chars[5] = CHAR_LF;
                    result.count    = CNT_W'(6);
                    st.line_chars   = '0;
                end
                st.pending = '0;
                st.phase   = PHASE_EMPTY;
            end
            PHASE_ONE:
            begin
                st.pending = {b0, data_byte};
                st.phase   = PHASE_TWO;
            end
            default:
            begin
                st.pending = {data_byte, 8'h00};
                st.phase   = PHASE_ONE;
            end
        endcase

        t0 = st.pending[15:8];
        t1 = st.pending[7:0];
        state_nxt = st;
        if (last_byte)
        begin
            if (st.phase == PHASE_ONE)
            begin
                result.chars[0] = b64_sym(t0[7:2]);
                result.chars[1] = b64_sym({t0[1:0], 4'h0});
                result.chars[2] = CHAR_PAD;
                result.chars[3] = CHAR_PAD;
                result.count    = CNT_W'(4);
            end
            else if (st.phase == PHASE_TWO)
            begin
                result.chars[0] = b64_sym(t0[7:2]);
                result.chars[1] = b64_sym({t0[1:0], t1[7:4]});
                result.chars[2] = b64_sym({t1[3:0], 2'b00});
                result.chars[3] = CHAR_PAD;
                result.count    = CNT_W'(4);
            end
            state_nxt = '0;
        end
    end

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the base64 encoder with cr lf line wrapping
`timescale 1ns / 100ps

module testbench;

    import b64lw_pkg::*;

    localparam int LINE_CHARS   = 76;
    localparam int RANDOM_BYTES = 50;
    localparam int SETTLE_TICKS = 20;
    localparam int IDLE_PERCENT = 32;

    localparam logic [8*64-1:0] B64_TABLE =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // data_byte[7:0]
    logic       s_tlast;   // last_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // out_char[7:0]
    logic       m_tlast;   // out_last

    enc_char_t   awaited_chars [$];
    logic [15:0] enc_pending;
    logic [1:0]  enc_phase;
    logic [6:0]  enc_line;

    bit tx_idle_en;
    bit rx_idle_en;
    int stall_left;
    int mismatch_count;
    int bytes_sent;
    int messages_sent;
    int chars_checked;
    int line_breaks;

    base64_encoder_line_wrap_core #(
        .LINE_CHARS(LINE_CHARS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return B64_TABLE[8*(63-v) +: 8];
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic last);
        logic [7:0] chars [$];
        logic [7:0] b0;
        logic [7:0] b1;
        b0 = enc_pending[15:8];
        b1 = enc_pending[7:0];
        case (enc_phase)
            PHASE_TWO:
            begin
                chars.push_back(b64_char(b0[7:2]));
                chars.push_back(b64_char({b0[1:0], b1[7:4]}));
                chars.push_back(b64_char({b1[3:0], b[7:6]}));
                chars.push_back(b64_char(b[5:0]));
                enc_line = enc_line + 7'd4;
                if (enc_line >= LINE_CHARS)
                begin
                    chars.push_back(CHAR_CR);
                    chars.push_back(CHAR_LF);
                    enc_line = '0;
                    line_breaks++;
                end
                enc_pending = '0;
                enc_phase = PHASE_EMPTY;
            end
            PHASE_ONE:
            begin
                enc_pending = {b0, b};
                enc_phase = PHASE_TWO;
            end
            default:
            begin
                enc_pending = {b, 8'h00};
                enc_phase = PHASE_ONE;
            end
        endcase
        if (last)
        begin
            b0 = enc_pending[15:8];
            b1 = enc_pending[7:0];
            if (enc_phase == PHASE_ONE)
            begin
                chars.push_back(b64_char(b0[7:2]));
                chars.push_back(b64_char({b0[1:0], 4'b0000}));
                chars.push_back(CHAR_PAD);
                chars.push_back(CHAR_PAD);
            end
            else if (enc_phase == PHASE_TWO)
            begin
                chars.push_back(b64_char(b0[7:2]));
                chars.push_back(b64_char({b0[1:0], b1[7:4]}));
                chars.push_back(b64_char({b1[3:0], 2'b00}));
                chars.push_back(CHAR_PAD);
            end
            enc_pending = '0;
            enc_phase = PHASE_EMPTY;
            enc_line = '0;
        end
        foreach (chars[i])
        begin
            awaited_chars.push_back('{ch: chars[i], last: (i == chars.size() - 1)});
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 30)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // output side: check each transaction against the oldest awaited char
    always @(posedge clk)
    begin
        enc_char_t exp_char;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char 0x%02h", m_tdata));
            end
            else
            begin
                exp_char = awaited_chars.pop_front();
                if (m_tdata !== exp_char.ch)
                begin
                    report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                              m_tdata, exp_char.ch));
                end
                if (m_tlast !== exp_char.last)
                begin
                    report_mismatch($sformatf("tlast %b, want %b on char 0x%02h",
                                              m_tlast, exp_char.last, exp_char.ch));
                end
                chars_checked++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            m_tready <= !(rx_idle_en && ($urandom_range(0, 99) < IDLE_PERCENT));
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        while (tx_idle_en && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        encode_byte(data, last);
        bytes_sent++;
        if (last)
        begin
            messages_sent++;
        end
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic test_directed_edges();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h20, 1'b1);
        wait_drained();
    endtask

    task automatic test_line_wrap();
        // break on the closing group, then a break followed by padding
        send_message(LINE_CHARS / 4 * 3);
        send_message(LINE_CHARS / 4 * 3 + 1);
        send_message(LINE_CHARS / 4 * 3 * 2 + 2);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_message(5);
        send_message(31);
        send_message(1);
        send_message(24);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        @(posedge clk);
        stall_left = 300;
        send_message(40);
        tx_idle_en = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_messages();
        int start_bytes;
        int pick;
        int len;
        start_bytes = bytes_sent;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                len = $urandom_range(1, 6);
            end
            else if (pick < 90)
            begin
                len = $urandom_range(7, 30);
            end
            else
            begin
                len = $urandom_range(31, 90);
            end
            send_message(len);
            if ($urandom_range(0, 9) == 0)
            begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        tx_idle_en     = 1'b0;
        rx_idle_en     = 1'b0;
        stall_left     = 0;
        mismatch_count = 0;
        bytes_sent     = 0;
        messages_sent  = 0;
        chars_checked  = 0;
        line_breaks    = 0;
        enc_pending    = '0;
        enc_phase      = PHASE_EMPTY;
        enc_line       = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_edges();
        test_line_wrap();
        test_back_to_back();
        test_output_backpressure();
        test_random_messages();

        $display("summary: %0d bytes in %0d messages, %0d chars checked, %0d line breaks",
                 bytes_sent, messages_sent, chars_checked, line_breaks);
        $display("summary: one and two byte padding, wrap at %0d columns, long output stall",
                 LINE_CHARS);
        if (mismatch_count == 0 && awaited_chars.size() == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d chars still awaited", awaited_chars.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/b64lw_pkg.sv
hw/rtl/b64lw_group_enc.sv
hw/rtl/base64_encoder_line_wrap_core.sv
tb/sv/testbench.sv
